### rtl/core/sfcs_pkg.sv
// sfcs_pkg: shared constants, status codes and the frame job type for the
// sensor frame CRC and scale block. No dependencies.
`default_nettype none

package sfcs_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [3:0] LAST_POS = 4'd8;   // position of the third CRC byte

  // quotient_status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic signed [23:0] FIX_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] FIX_MIN = 24'sh800000;

  // One completed frame, handed from the byte front end to the divider.
  typedef struct packed {
    logic [15:0] pressure;
    logic [15:0] temperature;
    logic [15:0] scale;
    logic [2:0]  fail_mask;
  } sfcs_job_t;

endpackage

`default_nettype wire

### rtl/core/sfcs_if.sv
// sfcs_if: valid/ready channel interfaces for frame bytes and results.
// Depends on nothing but the language.
`default_nettype none

interface sfcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pressure_fixed;
  logic signed [15:0] pressure_raw;
  logic signed [15:0] temperature_raw;
  logic signed [15:0] scale_factor;
  logic [2:0]         crc_fail_mask;
  logic [1:0]         quotient_status;

  modport source (output valid, output pressure_fixed, output pressure_raw,
                  output temperature_raw, output scale_factor, output crc_fail_mask,
                  output quotient_status, input ready);
  modport sink   (input valid, input pressure_fixed, input pressure_raw,
                  input temperature_raw, input scale_factor, input crc_fail_mask,
                  input quotient_status, output ready);
endinterface

`default_nettype wire

### rtl/core/sfcs_front.sv
// sfcs_front: byte front end. Tracks frame position, runs the CRC-8 per word,
// assembles words and pushes one job per frame. Uses sfcs_pkg, sfcs_if.
`default_nettype none

module sfcs_front
  import sfcs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sfcs_in_if.sink    frame,
  input  wire logic  queue_full,
  output logic       job_push,
  output sfcs_job_t  job
);

  typedef enum logic [1:0] {ROLE_HIGH, ROLE_LOW, ROLE_CHECK} role_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  logic [3:0]  pos;
  logic [7:0]  crc;
  logic [7:0]  hold;
  logic [15:0] pressure_word;
  logic [15:0] temperature_word;
  logic [15:0] scale_word;
  logic [2:0]  fail_bits;

  logic        accept;
  logic [3:0]  pos_eff;
  role_t       role;
  logic [1:0]  word;
  logic [2:0]  fail_base;
  logic [2:0]  fail_next;
  logic [7:0]  crc_base;
  logic [7:0]  crc_next;
  logic [15:0] word_value;

  assign frame.ready = !queue_full;
  assign accept      = frame.valid && frame.ready;

  always_comb begin
    if (frame.frame_start || pos > LAST_POS) begin
      pos_eff = '0;
    end else begin
      pos_eff = pos;
    end
  end

  always_comb begin
    case (pos_eff)
      4'd0, 4'd3, 4'd6: role = ROLE_HIGH;
      4'd1, 4'd4, 4'd7: role = ROLE_LOW;
      default:          role = ROLE_CHECK;
    endcase
    case (pos_eff)
      4'd0, 4'd1, 4'd2: word = 2'd0;
      4'd3, 4'd4, 4'd5: word = 2'd1;
      default:          word = 2'd2;
    endcase
  end

  assign crc_base   = (role == ROLE_HIGH) ? CRC_INIT : crc;
  assign crc_next   = crc_fold(crc_base, frame.rx_byte);
  assign word_value = {hold, frame.rx_byte};
  assign fail_base  = (pos_eff == 4'd0) ? 3'b000 : fail_bits;

  always_comb begin
    fail_next = fail_base;
    if (role == ROLE_CHECK && crc != frame.rx_byte) begin
      fail_next = fail_base | (3'b001 << word);
    end
  end

  assign job_push        = accept && (pos_eff == LAST_POS);
  assign job.pressure    = pressure_word;
  assign job.temperature = temperature_word;
  assign job.scale       = scale_word;
  assign job.fail_mask   = fail_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      crc              <= CRC_INIT;
      hold             <= '0;
      pressure_word    <= '0;
      temperature_word <= '0;
      scale_word       <= '0;
      fail_bits        <= '0;
    end else if (accept) begin
      pos       <= (pos_eff == LAST_POS) ? 4'd0 : pos_eff + 4'd1;
      fail_bits <= fail_next;
      case (role)
        ROLE_HIGH: begin
          crc  <= crc_next;
          hold <= frame.rx_byte;
        end
        ROLE_LOW: begin
          crc <= crc_next;
          case (word)
            2'd0:    pressure_word    <= word_value;
            2'd1:    temperature_word <= word_value;
            default: scale_word       <= word_value;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/sfcs_fifo.sv
// sfcs_fifo: small register queue between the front end and the divider.
// Depends on nothing but the language.
`default_nettype none

module sfcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/sfcs_back.sv
// sfcs_back: back end. Bit-serial restoring divider for pressure/scale,
// saturation and the result register. Uses sfcs_pkg, sfcs_if.
`default_nettype none

module sfcs_back
  import sfcs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_valid,
  output logic            job_pop,
  input  wire sfcs_job_t  job,
  sfcs_out_if.source      result
);

  localparam int NUM_W = 16 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int MAG_W = (NUM_W > 25) ? NUM_W : 25;
  localparam int POS_LIM = 8388607;
  localparam int NEG_LIM = 8388608;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

  state_t       state;
  logic [CNT_W-1:0] cnt;
  logic [15:0]  rem;
  logic [NUM_W-1:0] shreg;     // numerator bits out the top, quotient bits in
  logic [15:0]  dsor;
  logic         neg;
  logic         zero;
  sfcs_job_t    cur;

  logic               out_valid;
  logic signed [23:0] out_fixed;
  logic [15:0]        out_p;
  logic [15:0]        out_t;
  logic [15:0]        out_s;
  logic [2:0]         out_mask;
  logic [1:0]         out_status;

  logic [15:0]        p_mag;
  logic [15:0]        s_mag;
  logic [16:0]        trial;
  logic               ge;
  logic [MAG_W-1:0]   mag;
  logic signed [23:0] q_val;
  logic [1:0]         q_status;
  logic               out_free;

  assign p_mag    = job.pressure[15] ? 16'(-job.pressure) : job.pressure;
  assign s_mag    = job.scale[15] ? 16'(-job.scale) : job.scale;
  assign job_pop  = (state == S_IDLE) && job_valid;
  assign trial    = {rem, shreg[NUM_W-1]};
  assign ge       = (trial >= {1'b0, dsor});
  assign mag      = MAG_W'(shreg);
  assign out_free = !out_valid || result.ready;

  always_comb begin
    if (zero) begin
      q_val    = '0;
      q_status = ST_ZERO;
    end else if (neg) begin
      if (mag > MAG_W'(NEG_LIM)) begin
        q_val    = FIX_MIN;
        q_status = ST_SAT;
      end else begin
        q_val    = -$signed(24'(mag));
        q_status = ST_OK;
      end
    end else begin
      if (mag > MAG_W'(POS_LIM)) begin
        q_val    = FIX_MAX;
        q_status = ST_SAT;
      end else begin
        q_val    = $signed(24'(mag));
        q_status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a new result, or drop the current one once taken
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            shreg <= NUM_W'(p_mag) << FRAC_BITS;
            dsor  <= s_mag;
            neg   <= job.pressure[15] ^ job.scale[15];
            zero  <= (job.scale == '0);
            rem   <= '0;
            cnt   <= CNT_W'(NUM_W - 1);
            state <= (job.scale == '0) ? S_FIN : S_DIV;
          end
        end
        S_DIV: begin
          rem   <= ge ? 16'(trial - {1'b0, dsor}) : trial[15:0];
          shreg <= {shreg[NUM_W-2:0], ge};
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_fixed  <= q_val;
            out_p      <= cur.pressure;
            out_t      <= cur.temperature;
            out_s      <= cur.scale;
            out_mask   <= cur.fail_mask;
            out_status <= q_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid           = out_valid;
  assign result.pressure_fixed  = out_fixed;
  assign result.pressure_raw    = $signed(out_p);
  assign result.temperature_raw = $signed(out_t);
  assign result.scale_factor    = $signed(out_s);
  assign result.crc_fail_mask   = out_mask;
  assign result.quotient_status = out_status;

`ifndef SYNTHESIS
  a_zero_scale: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.quotient_status == ST_ZERO) |->
      (result.pressure_fixed == '0 && result.scale_factor == '0))
    else $error("zero scale result carries nonzero quotient");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.quotient_status == ST_SAT) |->
      (result.pressure_fixed == FIX_MAX || result.pressure_fixed == FIX_MIN))
    else $error("saturated result not at a rail");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.quotient_status == ST_OK ||
                      result.quotient_status == ST_ZERO ||
                      result.quotient_status == ST_SAT))
    else $error("undefined quotient status");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> !$past(job_pop))
    else $error("job taken while divider busy");
`endif

endmodule

`default_nettype wire

### rtl/core/sensor_frame_crc_and_scale.sv
// sensor_frame_crc_and_scale: top level of the sensor frame checker/scaler.
// Instantiates sfcs_front, sfcs_fifo and sfcs_back; uses sfcs_pkg, sfcs_if.
`default_nettype none

// Takes a 9-byte pressure sensor frame one byte per transaction on "frame":
// three big-endian words (pressure, temperature, scale), each followed by a
// CRC-8 byte (poly 0x31, init 0xFF, no final XOR). frame_start forces the byte
// to position 0; without it frames run back to back. On the ninth byte one
// result transaction follows on "result" with the raw words, the CRC fail mask
// and pressure * 2^FRAC_BITS / scale, truncated toward zero and saturated to
// 24 bits (status 1 for zero scale, 2 for saturation). Results are given even
// on CRC failure.
// Timing: the front end takes one byte per cycle while the job queue
// (QDEPTH frames) has room. The back end handles each frame in a load step,
// 16 + FRAC_BITS divider iterations at one quotient bit per cycle (skipped
// for zero scale) and a finalize step, so the sustained rate is set by the
// serial divider, which takes no new frame until the last one is finished.
// A stalled result register holds the divider in its final step, and the
// queue then fills and drops frame.ready.

module sensor_frame_crc_and_scale
  import sfcs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,  // 0..16
  parameter int QDEPTH    = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sfcs_in_if.sink    frame,
  sfcs_out_if.source result
);

  sfcs_job_t push_job;
  sfcs_job_t pop_job;
  logic      push;
  logic      full;
  logic      pop;
  logic      nonempty;

  // byte position, CRC and word assembly
  sfcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .queue_full (full),
    .job_push   (push),
    .job        (push_job)
  );

  // decouples byte intake from the divider
  sfcs_fifo #(
    .WIDTH ($bits(sfcs_job_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (push_job),
    .full     (full),
    .pop      (pop),
    .rdata    (pop_job),
    .nonempty (nonempty)
  );

  // serial divide, saturate, result register
  sfcs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (nonempty),
    .job_pop   (pop),
    .job       (pop_job),
    .result    (result)
  );

endmodule

`default_nettype wire
